@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the text console writer RTL.
// Included by the top level; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// Text console writer package: grid geometry, field widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int ROWS       = 25;
   localparam int COLUMNS    = 80;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = 11;
   localparam int VALUE_W   = 16;
   localparam int CROW_W    = 5;
   localparam int CCOL_W    = 7;
   localparam int COLOUR_W  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
   localparam logic [VALUE_W-1:0] RESET_CELL   = 16'h0F20;

   typedef struct packed {
      logic [COLOUR_W-1:0] foreground;
      logic [COLOUR_W-1:0] background;
   } tcw_cfg_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [VALUE_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr;
   } tcw_ram_req_type;

   typedef struct packed {
      logic init;
      logic busy;
   } tcw_stat_type;

endpackage

@@ hw/rtl/tcw_if.sv @@
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::OP_W-1:0]      operation;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::IDX_W-1:0]     cell_index;

   modport source (output valid, operation, char_code, cell_index, input ready);
   modport sink   (input valid, operation, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::VALUE_W-1:0]   cell_value;
   logic [tcw_pkg::CROW_W-1:0]    cursor_row;
   logic [tcw_pkg::CCOL_W-1:0]    cursor_column;
   logic                          scrolled;

   modport source (output valid, cell_value, cursor_row, cursor_column, scrolled,
                   input ready);
   modport sink   (input valid, cell_value, cursor_row, cursor_column, scrolled,
                   output ready);
endinterface

@@ hw/rtl/tcw_csr.sv @@
// Colour registers behind an APB-style port.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output tcw_pkg::tcw_cfg_type            cfg
);

   localparam logic REG_FOREGROUND = 1'b0;
   localparam logic REG_BACKGROUND = 1'b1;

   tcw_pkg::tcw_cfg_type cfg_ff, cfg_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_FOREGROUND: cfg_in.foreground = pwdata[tcw_pkg::COLOUR_W-1:0];
            REG_BACKGROUND: cfg_in.background = pwdata[tcw_pkg::COLOUR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FOREGROUND: prdata = tcw_pkg::CSR_DATA_W'(cfg_ff.foreground);
         REG_BACKGROUND: prdata = tcw_pkg::CSR_DATA_W'(cfg_ff.background);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.foreground <= 4'hF;
         cfg_ff.background <= 4'h0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/tcw_cell_ram.sv @@
// Cell store: one write port, one registered read port.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cell_ram (
   input  logic                          clock,
   input  tcw_pkg::tcw_ram_req_type      ram_req,
   output logic [tcw_pkg::VALUE_W-1:0]   rdata
);

   logic [tcw_pkg::VALUE_W-1:0] mem [tcw_pkg::CELL_COUNT];
   logic [tcw_pkg::VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[ram_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
// Sequencer: cursor, item execution and the address sweep for scroll, clear and init.
// Depends on tcw_pkg and tcw_if.
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   tcw_req_if.sink                       req,
   tcw_rsp_if.source                     rsp,
   input  tcw_pkg::tcw_cfg_type          cfg,
   output tcw_pkg::tcw_ram_req_type      ram_req,
   input  logic [tcw_pkg::VALUE_W-1:0]   rdata,
   output tcw_pkg::tcw_stat_type         stat
);

   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_DONE   = 3'd3;
   localparam logic [2:0] S_SCOPY  = 3'd4;
   localparam logic [2:0] S_SLAST  = 3'd5;
   localparam logic [2:0] S_FILL   = 3'd6;

   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(tcw_pkg::COPY_COUNT - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(tcw_pkg::CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(tcw_pkg::COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(tcw_pkg::COLUMNS - 1);

   logic [2:0]                     state_ff, state_in;
   logic [ADDR_W-1:0]              cnt_ff, cnt_in;
   logic                           init_ff, init_in;
   logic [tcw_pkg::OP_W-1:0]       op_ff, op_in;
   logic [tcw_pkg::CHAR_W-1:0]     ch_ff, ch_in;
   logic [tcw_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [ROW_W-1:0]               row_ff, row_in;
   logic [COL_W-1:0]               col_ff, col_in;
   logic                           scrolled_ff, scrolled_in;
   logic [tcw_pkg::VALUE_W-1:0]    value_ff, value_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [tcw_pkg::CROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::CCOL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic                           rsp_scr_ff, rsp_scr_in;

   logic                           slot_free;
   logic                           load_rsp;
   logic                           wrap;
   logic                           need_scroll;
   logic [ADDR_W-1:0]              cursor_addr;
   logic [tcw_pkg::VALUE_W-1:0]    blank;
   logic [tcw_pkg::CHAR_W-1:0]     attr;

   assign slot_free   = !rsp_valid_ff || rsp.ready;
   assign attr        = {cfg.background, cfg.foreground};
   assign blank       = init_ff ? tcw_pkg::RESET_CELL : {attr, tcw_pkg::SPACE_CODE};
   assign cursor_addr = ADDR_W'(ADDR_W'(row_ff) * ROW_STEP + ADDR_W'(col_ff));
   assign wrap        = (ch_ff == tcw_pkg::NEWLINE_CODE) || (col_ff == COL_LAST);
   assign need_scroll = wrap && (row_ff == ROW_LAST);

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      init_in     = init_ff;
      op_in       = op_ff;
      ch_in       = ch_ff;
      idx_in      = idx_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      scrolled_in = scrolled_ff;
      value_in    = value_ff;
      load_rsp    = 1'b0;

      ram_req.we    = 1'b0;
      ram_req.waddr = cnt_ff;
      ram_req.wdata = blank;
      ram_req.raddr = ADDR_W'(idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in       = req.operation;
               ch_in       = req.char_code;
               idx_in      = req.cell_index;
               scrolled_in = 1'b0;
               value_in    = '0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               tcw_pkg::OP_PUT: begin
                  if (need_scroll || slot_free) begin
                     if (ch_ff != tcw_pkg::NEWLINE_CODE) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cursor_addr;
                        ram_req.wdata = {attr, ch_ff};
                     end
                     col_in = wrap ? '0 : COL_W'(col_ff + COL_W'(1));
                     if (wrap && !need_scroll) begin
                        row_in = ROW_W'(row_ff + ROW_W'(1));
                     end
                     if (need_scroll) begin
                        scrolled_in = 1'b1;
                        cnt_in      = '0;
                        state_in    = S_SCOPY;
                     end else begin
                        load_rsp = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
               end
               tcw_pkg::OP_READ: begin
                  if (int'(idx_ff) < tcw_pkg::CELL_COUNT) begin
                     state_in = S_RDWAIT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  cnt_in   = '0;
                  state_in = S_FILL;
               end
               default: begin
                  if (slot_free) begin
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_RDWAIT: begin
            value_in = rdata;
            state_in = S_DONE;
         end
         S_SCOPY: begin
            // read one row ahead, write back the previous read in the next cycle
            ram_req.raddr = ADDR_W'(cnt_ff + ROW_STEP);
            ram_req.we    = (cnt_ff != '0);
            ram_req.waddr = ADDR_W'(cnt_ff - ADDR_W'(1));
            ram_req.wdata = rdata;
            cnt_in        = ADDR_W'(cnt_ff + ADDR_W'(1));
            if (cnt_ff == COPY_LAST) begin
               state_in = S_SLAST;
            end
         end
         S_SLAST: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = ADDR_W'(cnt_ff - ADDR_W'(1));
            ram_req.wdata = rdata;
            state_in      = S_FILL;
         end
         S_FILL: begin
            ram_req.we = 1'b1;
            cnt_in     = ADDR_W'(cnt_ff + ADDR_W'(1));
            if (cnt_ff == CELL_LAST) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = value_ff;
         rsp_row_in   = tcw_pkg::CROW_W'(row_in);
         rsp_col_in   = tcw_pkg::CCOL_W'(col_in);
         rsp_scr_in   = scrolled_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      idx_ff       <= idx_in;
      scrolled_ff  <= scrolled_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.cell_value    = rsp_value_ff;
   assign rsp.cursor_row    = rsp_row_ff;
   assign rsp.cursor_column = rsp_col_ff;
   assign rsp.scrolled      = rsp_scr_ff;

   assign stat.init = init_ff;
   assign stat.busy = (state_ff != S_IDLE);

endmodule

@@ hw/rtl/text_console_writer_core.sv @@
// channel  direction  handshake       payload
// req_ch   in         valid/ready     operation, char_code, cell_index
// rsp_ch   out        valid/ready     cell_value, cursor_row, cursor_column, scrolled
// csr      in         APB write/read  foreground_colour @0x0, background_colour @0x4
//
// One item at a time through one sequencer and one cell store.
// Scroll adds one pass over the store.
// After reset the store is swept to blank; no item taken.
// A result waits in the output register; a stalled rsp_ch holds the next result back.
// Depends on tcw_pkg, tcw_if, tcw_csr, tcw_cell_ram, tcw_ctrl, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_writer_core (
   input  logic                            clock,
   input  logic                            reset,
   tcw_req_if.sink                         req_ch,
   tcw_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   tcw_pkg::tcw_cfg_type        cfg;
   tcw_pkg::tcw_ram_req_type    ram_req;
   tcw_pkg::tcw_stat_type       stat;
   logic [tcw_pkg::VALUE_W-1:0] rdata;
   logic                        req_fire;
   logic                        init_hold;
   logic                        waddr_ok;
   logic                        cursor_ok;

   tcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcw_cell_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   tcw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .cfg     (cfg),
      .ram_req (ram_req),
      .rdata   (rdata),
      .stat    (stat)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign init_hold = !req_ch.ready && stat.busy;
   assign waddr_ok  = int'(ram_req.waddr) < tcw_pkg::CELL_COUNT;
   assign cursor_ok = (int'(rsp_ch.cursor_row) < tcw_pkg::ROWS) &&
                      (int'(rsp_ch.cursor_column) < tcw_pkg::COLUMNS);

   `TCW_ASSERT_NEXT(a_one_item, clock, reset, req_fire, !req_ch.ready, "item accepted while busy")
   `TCW_ASSERT_IMPLY(a_init_blocks, clock, reset, stat.init, init_hold, "item taken in init")
   `TCW_ASSERT_IMPLY(a_waddr_range, clock, reset, ram_req.we, waddr_ok, "write out of range")
   `TCW_ASSERT_IMPLY(a_cursor_range, clock, reset, rsp_ch.valid, cursor_ok, "cursor out of grid")

endmodule

@@ tb/sv/tcw_tb_pkg.sv @@
// Testbench constants and the result record for the text console writer bench.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

package tcw_tb_pkg;

   localparam logic [tcw_pkg::CSR_ADDR_W-1:0] FG_COLOUR_ADDR = 3'h0;
   localparam logic [tcw_pkg::CSR_ADDR_W-1:0] BG_COLOUR_ADDR = 3'h4;

   // opcode the block leaves unused: no state change
   localparam logic [tcw_pkg::OP_W-1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [tcw_pkg::VALUE_W-1:0] cell_value;
      logic [tcw_pkg::CROW_W-1:0]  cursor_row;
      logic [tcw_pkg::CCOL_W-1:0]  cursor_column;
      logic                        scrolled;
   } console_status_type;

endpackage

@@ tb/sv/tcw_console_checker.sv @@
// Console checker: tracks screen, cursor and colours from accepted items and register
// writes, and compares every result item with the predicted cursor and cell state.
// Depends on tcw_pkg, tcw_tb_pkg and tcw_if.
`timescale 1ns / 1ps

module tcw_console_checker
   import tcw_pkg::*, tcw_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if                    req_ch,
   tcw_rsp_if                    rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   logic [VALUE_W-1:0]  screen [CELL_COUNT];
   logic [CROW_W-1:0]   cur_row;
   logic [CCOL_W-1:0]   cur_col;
   logic [COLOUR_W-1:0] fg_colour;
   logic [COLOUR_W-1:0] bg_colour;
   console_status_type  pending_status [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic next_line(output logic did_scroll);
      cur_col    = '0;
      did_scroll = (cur_row == ROWS - 1);
      if (did_scroll) begin
         for (int i = 0; i < COPY_COUNT; i++)
            screen[i] = screen[i + COLUMNS];
         for (int i = COPY_COUNT; i < CELL_COUNT; i++)
            screen[i] = {bg_colour, fg_colour, SPACE_CODE};
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endtask

   task automatic apply_console_op(input logic [OP_W-1:0]   op,
                                   input logic [CHAR_W-1:0] ch,
                                   input logic [IDX_W-1:0]  idx);
      console_status_type st;
      logic               sc;
      st = '0;
      sc = 1'b0;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CODE) begin
               next_line(sc);
            end else begin
               screen[cur_row * COLUMNS + cur_col] = {bg_colour, fg_colour, ch};
               if (cur_col == COLUMNS - 1)
                  next_line(sc);
               else
                  cur_col = cur_col + 1'b1;
            end
         end
         OP_READ: begin
            if (idx < CELL_COUNT)
               st.cell_value = screen[idx];
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen[i] = {bg_colour, fg_colour, SPACE_CODE};
         end
         default: ;
      endcase
      st.scrolled      = sc;
      st.cursor_row    = cur_row;
      st.cursor_column = cur_col;
      pending_status.push_back(st);
   endtask

   always @(posedge clock) begin
      console_status_type want;
      console_status_type got;
      if (reset) begin
         for (int i = 0; i < CELL_COUNT; i++)
            screen[i] = RESET_CELL;
         cur_row   = '0;
         cur_col   = '0;
         fg_colour = RESET_CELL[8 +: COLOUR_W];
         bg_colour = RESET_CELL[12 +: COLOUR_W];
         pending_status.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.cell_value, rsp_ch.cursor_row, rsp_ch.cursor_column,
                   rsp_ch.scrolled};
            if (pending_status.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result item: value %h row %0d col %0d scrolled %b",
                           got.cell_value, got.cursor_row, got.cursor_column, got.scrolled);
               mismatches++;
            end else begin
               want = pending_status.pop_front();
               if (got.cell_value != want.cell_value || got.cursor_row != want.cursor_row
                   || got.cursor_column != want.cursor_column
                   || got.scrolled != want.scrolled) begin
                  if (mismatches < 10)
                     $display("result mismatch: expected %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                              want.cell_value, want.cursor_row, want.cursor_column,
                              want.scrolled, got.cell_value, got.cursor_row,
                              got.cursor_column, got.scrolled);
                  mismatches++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               FG_COLOUR_ADDR: fg_colour = pwdata[COLOUR_W-1:0];
               BG_COLOUR_ADDR: bg_colour = pwdata[COLOUR_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            apply_console_op(req_ch.operation, req_ch.char_code, req_ch.cell_index);
      end
      outstanding = pending_status.size();
   end

endmodule

@@ tb/sv/tb_text_console_writer_core.sv @@
// Top of the text console writer bench: clock, reset, item and register stimulus,
// random receiver stalls, watchdog and verdict. Depends on tcw_pkg, tcw_tb_pkg,
// tcw_if, tcw_console_checker and text_console_writer_core.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
   import tcw_pkg::*;
   import tcw_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PRESSURE_HOLD  = 400;
   localparam int DRAIN_CYCLES   = 2100;
   localparam int PHASE_ITEMS    = 222;
   localparam int PHASES         = 6;
   localparam int MAX_INDEX      = 2**IDX_W - 1;

   // colour plan per phase, extremes first; the last phase picks at random
   localparam logic [4*5-1:0] FG_PLAN = {4'd9, 4'd15, 4'd0, 4'd15, 4'd0};
   localparam logic [4*5-1:0] BG_PLAN = {4'd6, 4'd0, 4'd15, 4'd15, 4'd0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatches;
   int outstanding;
   int idle_cycles   = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int gap_style     = 1;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   text_console_writer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tcw_console_checker console_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_text_console_writer_core NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random ready pattern, plus a long hold whenever one is requested
   initial begin
      int span;
      int pick;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rsp_ch.ready <= 1'b0;
            span = PRESSURE_HOLD;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               rsp_ch.ready <= 1'b1;
               span = $urandom_range(100, 300);
            end else if (pick < 60) begin
               rsp_ch.ready <= 1'b1;
               span = $urandom_range(1, 30);
            end else if (pick < 95) begin
               rsp_ch.ready <= 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               rsp_ch.ready <= 1'b0;
               span = $urandom_range(20, 80);
            end
         end
         repeat (span - 1) @(posedge clock);
      end
   end

   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0]  idx);
      int gap;
      int pick;
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (gap_style != 0) begin
         if (pick >= 90)
            gap = $urandom_range(8, 50);
         else if (pick >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.char_code  <= ch;
      req_ch.cell_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_item();
      int                pick;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      idx  = IDX_W'($urandom_range(0, MAX_INDEX));
      if (pick < 64)
         send_item(OP_PUT, ch, idx);
      else if (pick < 70)
         send_item(OP_PUT, NEWLINE_CODE, idx);
      else if (pick < 88)
         send_item(OP_READ, ch, IDX_W'($urandom_range(0, CELL_COUNT - 1)));
      else if (pick < 90)
         send_item(OP_READ, ch, IDX_W'($urandom_range(CELL_COUNT, MAX_INDEX)));
      else if (pick < 92)
         send_item(OP_CLEAR, ch, idx);
      else if (pick < 96)
         send_item(OP_READ, ch, IDX_W'($urandom_range(COPY_COUNT, CELL_COUNT - 1)));
      else
         send_item(OP_NONE, ch, idx);
   endtask

   // one register write; leaves the port idle afterwards
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [COLOUR_W-1:0]   value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [COLOUR_W-1:0] fg;
      logic [COLOUR_W-1:0] bg;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_PUT;
      req_ch.char_code  <= '0;
      req_ch.cell_index <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, reads off the grid, unused opcode, char extremes,
      // newline, ignored fields, clear
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'hFF, IDX_W'(CELL_COUNT - 1));
      send_item(OP_READ, 8'hFF, IDX_W'(CELL_COUNT));
      send_item(OP_READ, 8'h00, IDX_W'(MAX_INDEX));
      send_item(OP_NONE, 8'hFF, IDX_W'(MAX_INDEX));
      send_item(OP_NONE, 8'h00, 11'd0);
      send_item(OP_PUT, 8'h00, IDX_W'(MAX_INDEX));
      send_item(OP_PUT, 8'hFF, 11'd0);
      send_item(OP_PUT, 8'h41, 11'd0);
      send_item(OP_PUT, NEWLINE_CODE, IDX_W'(MAX_INDEX));
      send_item(OP_PUT, 8'h80, 11'd0);
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'h00, 11'd1);
      send_item(OP_READ, 8'h00, IDX_W'(COLUMNS));
      send_item(OP_CLEAR, 8'hFF, IDX_W'(MAX_INDEX));
      send_item(OP_READ, 8'h00, 11'd0);
      send_item(OP_READ, 8'h00, IDX_W'(COLUMNS));
      req_ch.valid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         if (phase < 5) begin
            fg = FG_PLAN[4*phase +: 4];
            bg = BG_PLAN[4*phase +: 4];
         end else begin
            fg = COLOUR_W'($urandom_range(0, 15));
            bg = COLOUR_W'($urandom_range(0, 15));
         end
         write_register(FG_COLOUR_ADDR, fg);
         write_register(BG_COLOUR_ADDR, bg);
         gap_style = phase % 3;
         if (phase == 1 || phase == 3)
            hold_requests = hold_requests + 1;
         repeat (PHASE_ITEMS) send_random_item();
         req_ch.valid <= 1'b0;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_text_console_writer_core OK");
      else
         $display("tb_text_console_writer_core NOT OK");
      $finish;
   end

endmodule

@@ text_console_writer_core.f @@
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_csr.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer_core.sv
tb/sv/tcw_tb_pkg.sv
tb/sv/tcw_console_checker.sv
tb/sv/tb_text_console_writer_core.sv
